>>> sv/bmm_pkg.sv
`default_nettype none

package bmm_pkg;

	typedef enum logic [1:0] {
		MODE_PERF   = 2'd0,
		MODE_NORMAL = 2'd1,
		MODE_SAVE   = 2'd2
	} bmm_mode_t;

	typedef enum logic [1:0] {
		REG_CAPACITY = 2'd0,
		REG_HIGH     = 2'd1,
		REG_LOW      = 2'd2,
		REG_CHARGE   = 2'd3
	} bmm_reg_t;

	localparam int unsigned CapW    = 18;
	localparam int unsigned PctW    = 7;
	localparam int unsigned WattW   = 14;
	localparam int unsigned CntW    = 32;
	localparam int unsigned EnergyW = 40;

	localparam logic [CapW-1:0]  CAP_RST    = 18'd150000;
	localparam logic [PctW-1:0]  HIGH_RST   = 7'd75;
	localparam logic [PctW-1:0]  LOW_RST    = 7'd25;
	localparam logic [WattW-1:0] CHG_RST    = 14'd900;
	localparam logic [CapW-1:0]  CHARGE_RST = 18'd120000;
	localparam logic [WattW-1:0] LOAD_WARN  = 14'd3000;

	// Percent thresholds, all scaled by the capacity
	typedef struct packed {
		logic [CapW-1:0]  cap;
		logic [WattW-1:0] chg_watts;
		logic [24:0]      hi;
		logic             hm5_neg;
		logic [24:0]      hm5;
		logic [24:0]      lo;
		logic [25:0]      lo10;
		logic [24:0]      on80;
		logic [27:0]      off955;
		logic [21:0]      warn15;
	} bmm_thr_t;

	localparam bmm_thr_t THR_RST = '{
		cap:       CAP_RST,
		chg_watts: CHG_RST,
		hi:        25'd11250000,
		hm5_neg:   1'b0,
		hm5:       25'd10500000,
		lo:        25'd3750000,
		lo10:      26'd5250000,
		on80:      25'd12000000,
		off955:    28'd143250000,
		warn15:    22'd2250000
	};

	// Result word; the last member sits in the lowest bits
	typedef struct packed {
		logic [CntW-1:0]    step_count;
		logic [EnergyW-1:0] energy_used;
		logic [CntW-1:0]    change_count;
		logic [CntW-1:0]    warning_count;
		logic               warning;
		logic [CapW-1:0]    charge_level;
		logic               charging;
		logic               mode_changed;
		logic [1:0]         mode;
	} bmm_res_t;

	function automatic logic [CntW-1:0] sat_inc32(input logic [CntW-1:0] v, input logic en);
		logic [CntW-1:0] r;
		r = v;
		if (en && (v != '1)) begin
			r = v + 32'd1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/bmm_cfg.sv
`default_nettype none

module bmm_cfg
	import bmm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [17:0] cfg_data,
	output bmm_thr_t         thr
);

	logic            wr;
	logic [CapW-1:0] cap_d;
	logic [PctW-1:0] hi_d;
	logic [PctW-1:0] lo_d;
	logic [PctW-1:0] hi_q;
	logic [PctW-1:0] lo_q;
	bmm_thr_t        thr_d;
	bmm_thr_t        thr_q;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;

	always_comb begin
		cap_d = thr_q.cap;
		hi_d  = hi_q;
		lo_d  = lo_q;
		thr_d = thr_q;
		if (wr) begin
			unique case (bmm_reg_t'(cfg_index))
				REG_CAPACITY: cap_d = cfg_data;
				REG_HIGH:     hi_d = cfg_data[PctW-1:0];
				REG_LOW:      lo_d = cfg_data[PctW-1:0];
				REG_CHARGE:   thr_d.chg_watts = cfg_data[WattW-1:0];
				default:      cap_d = thr_q.cap;
			endcase
		end
		// Rescale every threshold from the updated register values
		thr_d.cap     = cap_d;
		thr_d.hi      = {7'd0, cap_d} * {18'd0, hi_d};
		thr_d.hm5_neg = (hi_d < 7'd5);
		thr_d.hm5     = {7'd0, cap_d} * {18'd0, hi_d - 7'd5};
		thr_d.lo      = {7'd0, cap_d} * {18'd0, lo_d};
		thr_d.lo10    = {8'd0, cap_d} * {18'd0, {1'b0, lo_d} + 8'd10};
		thr_d.on80    = {1'b0, cap_d, 6'd0} + {3'd0, cap_d, 4'd0};
		thr_d.off955  = {10'd0, cap_d} * 28'd955;
		thr_d.warn15  = {cap_d, 4'd0} - {4'd0, cap_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q  <= HIGH_RST;
			lo_q  <= LOW_RST;
			thr_q <= THR_RST;
		end else if (wr) begin
			hi_q  <= hi_d;
			lo_q  <= lo_d;
			thr_q <= thr_d;
		end
	end

	assign thr = thr_q;

endmodule

`default_nettype wire

>>> sv/bmm_core.sv
`default_nettype none

module bmm_core
	import bmm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_en,
	input  wire logic [WattW-1:0] load,
	input  wire bmm_thr_t         thr,
	output bmm_res_t              res
);

	logic [CapW-1:0]    charge_q;
	bmm_mode_t          mode_q;
	logic               prev_valid_q;
	logic               chg_on_q;
	logic [CntW-1:0]    warns_q;
	logic [CntW-1:0]    changes_q;
	logic [CntW-1:0]    steps_q;
	logic [EnergyW-1:0] energy_q;

	logic [24:0]        c100;
	logic [27:0]        c1000;
	bmm_mode_t          mode_d;
	logic               changed;
	logic               chg_on_d;
	logic signed [19:0] sum;
	logic [CapW-1:0]    charge_d;
	logic [24:0]        n100;
	logic               warn;
	logic [EnergyW:0]   e_sum;
	logic [EnergyW-1:0] energy_d;
	logic [CntW-1:0]    warns_d;
	logic [CntW-1:0]    changes_d;
	logic [CntW-1:0]    steps_d;

	assign c100  = {7'd0, charge_q} * 25'd100;
	assign c1000 = {10'd0, charge_q} * 28'd1000;

	// Mode hysteresis on the charge held before the update
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_PERF: begin
				if (!thr.hm5_neg && (c100 < thr.hm5)) mode_d = MODE_NORMAL;
			end
			MODE_NORMAL: begin
				if (c100 >= thr.hi) mode_d = MODE_PERF;
				else if (c100 < thr.lo) mode_d = MODE_SAVE;
			end
			MODE_SAVE: begin
				if ({1'b0, c100} > thr.lo10) mode_d = MODE_NORMAL;
			end
			default: mode_d = MODE_NORMAL;
		endcase
	end

	assign changed = !prev_valid_q || (mode_d != mode_q);

	always_comb begin
		chg_on_d = chg_on_q;
		if (c100 < thr.on80) chg_on_d = 1'b1;
		else if (c1000 > thr.off955) chg_on_d = 1'b0;
	end

	always_comb begin
		sum = $signed({2'b00, charge_q}) - $signed({6'd0, load});
		if (chg_on_d) sum = sum + $signed({6'd0, thr.chg_watts});
		// clamp to [0, capacity]
		if (sum > $signed({2'b00, thr.cap})) charge_d = thr.cap;
		else if (sum[19]) charge_d = '0;
		else charge_d = sum[CapW-1:0];
	end

	assign n100 = {7'd0, charge_d} * 25'd100;
	assign warn = (n100 < {3'd0, thr.warn15}) || (load > LOAD_WARN);

	assign e_sum    = {1'b0, energy_q} + {27'd0, load};
	assign energy_d = e_sum[EnergyW] ? '1 : e_sum[EnergyW-1:0];

	assign warns_d   = sat_inc32(warns_q, warn);
	assign changes_d = sat_inc32(changes_q, changed);
	assign steps_d   = sat_inc32(steps_q, 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q     <= CHARGE_RST;
			mode_q       <= MODE_NORMAL;
			prev_valid_q <= 1'b0;
			chg_on_q     <= 1'b0;
			warns_q      <= '0;
			changes_q    <= '0;
			steps_q      <= '0;
			energy_q     <= '0;
		end else if (step_en) begin
			charge_q     <= charge_d;
			mode_q       <= mode_d;
			prev_valid_q <= 1'b1;
			chg_on_q     <= chg_on_d;
			warns_q      <= warns_d;
			changes_q    <= changes_d;
			steps_q      <= steps_d;
			energy_q     <= energy_d;
		end
	end

	always_comb begin
		res.step_count    = steps_d;
		res.energy_used   = energy_d;
		res.change_count  = changes_d;
		res.warning_count = warns_d;
		res.warning       = warn;
		res.charge_level  = charge_d;
		res.charging      = chg_on_d;
		res.mode_changed  = changed;
		res.mode          = mode_d;
	end

`ifndef NO_ASSERTIONS
	a_charge_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> (charge_q <= $past(thr.cap)))
		else $error("charge above capacity after a step");

	a_first_step_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !prev_valid_q |=> (changes_q != '0) && prev_valid_q)
		else $error("first step not counted as a mode change");

	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && (steps_q != '1) |=> (steps_q == $past(steps_q) + 32'd1))
		else $error("step counter did not advance");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(steps_q) && $stable(charge_q) && $stable(mode_q))
		else $error("state moved without a step");
`endif

endmodule

`default_nettype wire

>>> sv/battery_mode_manager.sv
// A word is held in the input register, its result in the result register.
// Throughput: one word per cycle unless m_axis_tready holds results back;
// the two registers let a new word enter while a finished result waits.
// Configuration writes take effect at the next edge, no wait states.
// Reset (arst_n low, asynchronous): charge 120000, normal mode, charger off,
// counters zero, registers at their documented defaults, both stages empty.
`default_nettype none

module battery_mode_manager
	import bmm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [15:0]  s_axis_tdata,  // load_watts[13:0], zero pad
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// mode[1:0], mode_changed, charging, charge_level[17:0], warning,
	// warning_count[31:0], change_count[31:0], energy_used[39:0],
	// step_count[31:0], zero pad
	output logic [159:0]      m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [17:0]  cfg_data
);

	logic             valid_s1;
	logic [WattW-1:0] load_s1;
	logic             valid_s2;
	bmm_res_t         res_s2;
	logic             advance;
	bmm_thr_t         thr;
	bmm_res_t         res;

	// advance the held word when the result slot is free or being drained
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			load_s1 <= s_axis_tdata[WattW-1:0];
		end
	end

	bmm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	bmm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.load    (load_s1),
		.thr     (thr),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, res_s2};

endmodule

`default_nettype wire
